@@ hw/rtl/joint_limit_interpolator_defines.svh @@
// assertion macros for the joint limit interpolator checker
`ifndef JOINT_LIMIT_INTERPOLATOR_DEFINES_SVH
`define JOINT_LIMIT_INTERPOLATOR_DEFINES_SVH

// antecedent implies consequent in the next cycle, outside reset
`define JLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the same cycle, outside reset
`define JLI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, reset included
`define JLI_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/jli_pkg.sv @@
// package with widths, register indexes and state type of the joint limit interpolator
package jli_pkg;
   localparam int MAX_POINTS_DEF = 16;
   localparam int NUM_TABLES_DEF = 2;
   localparam int VALUE_W        = 16;
   localparam int POINTS_W       = 5;
   localparam int CSR_INDEX_W    = 1;
   localparam int ENTRY_W        = 3 * VALUE_W;
   localparam int PROD_W         = 2 * (VALUE_W + 1);
   localparam int DVD_W          = 2 * VALUE_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_ANKLE_POINTS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_POINTS  = 1'b1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_LAST,
      S_CHK,
      S_SCAN,
      S_MUL,
      S_DIV,
      S_WAIT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctrl_type;

   function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [VALUE_W+2:0] v);
      logic signed [VALUE_W-1:0] r;
      if (v > $signed({{3{1'b0}}, 1'b0, {(VALUE_W-1){1'b1}}})) begin
         r = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (v < $signed({{3{1'b1}}, 1'b1, {(VALUE_W-1){1'b0}}})) begin
         r = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction
endpackage

@@ hw/rtl/jli_ram.sv @@
// generic single-port-write, registered-read ram
module jli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/jli_div.sv @@
// restoring divider, one quotient bit per cycle
module jli_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [jli_pkg::DVD_W-1:0]     dividend,
   input  logic [jli_pkg::VALUE_W-1:0]   divisor,
   output logic                          done,
   output logic [jli_pkg::DVD_W-1:0]     quotient
);
   import jli_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [VALUE_W:0]   rem_ff, rem_in;
   logic [VALUE_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [VALUE_W:0]   trial;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[VALUE_W-1:0], dvd_ff[DVD_W-1]};
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(DVD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
endmodule

@@ hw/rtl/joint_limit_interpolator.sv @@
// joint limit interpolator top level: breakpoint store, segment search and sequencer
// load: accepted while idle, no result, busy stays low
// query: at a table end the result follows the end check, else it follows the segment scan
//   (one store read per cycle), a multiply and 32 divider steps
// one request at a time; result strobe is a single cycle, receiver cannot stall
// synchronous reset clears control state and sets both point counts to 16
module joint_limit_interpolator #(
   parameter int MAX_POINTS = jli_pkg::MAX_POINTS_DEF,
   parameter int NUM_TABLES = jli_pkg::NUM_TABLES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic                              req_table_select,
   input  logic [3:0]                        req_point_index,
   input  logic signed [jli_pkg::VALUE_W-1:0] req_point_x,
   input  logic signed [jli_pkg::VALUE_W-1:0] req_point_low,
   input  logic signed [jli_pkg::VALUE_W-1:0] req_point_high,
   input  logic signed [jli_pkg::VALUE_W-1:0] req_query_x,
   input  logic                              req_query_bound,
   input  logic                              req_query_mirror,
   output logic                              rsp_valid,
   output logic signed [jli_pkg::VALUE_W-1:0] rsp_limit_value,
   input  logic                              csr_write_enable,
   input  logic [jli_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [jli_pkg::POINTS_W-1:0]      csr_data
);
   import jli_pkg::*;

   localparam int DEPTH = NUM_TABLES * MAX_POINTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int OW    = $clog2(MAX_POINTS);

   state_type state_ff, state_in;

   logic [POINTS_W-1:0] ankle_pts_ff, ankle_pts_in;
   logic [POINTS_W-1:0] head_pts_ff, head_pts_in;

   logic               table_ff, table_in;
   logic               col_ff, col_in;
   logic               mirror_ff, mirror_in;
   logic signed [VALUE_W-1:0] qx_ff, qx_in;
   logic signed [VALUE_W-1:0] prev_x_ff, prev_x_in;
   logic signed [VALUE_W-1:0] prev_y_ff, prev_y_in;
   logic signed [VALUE_W-1:0] last_y_ff, last_y_in;
   logic [OW-1:0]      idx_ff, idx_in;
   logic signed [VALUE_W:0] dy_ff, dy_in;
   logic [VALUE_W-1:0] dx_ff, dx_in;
   logic [VALUE_W-1:0] t_ff, t_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [VALUE_W-1:0] pre_ff, pre_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic               accept;
   logic               load_ok;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      base;
   logic [ENTRY_W-1:0] rd_entry;
   logic signed [VALUE_W-1:0] ent_x, ent_y;
   logic [POINTS_W-1:0] pts_raw;
   logic [OW-1:0]      last_off;
   logic               found;
   logic signed [VALUE_W:0] dx_full;
   logic [DVD_W-1:0]   prod_mag;
   logic [DVD_W-1:0]   quot;
   logic signed [VALUE_W+2:0] quot_s;
   logic signed [VALUE_W+2:0] sum;
   logic signed [VALUE_W+2:0] neg;
   div_ctrl_type       div_ctrl;

   assign accept  = start && !busy;
   assign load_ok = (int'(req_table_select) < NUM_TABLES) && (int'(req_point_index) < MAX_POINTS);
   assign wr_addr = AW'(int'(req_table_select) * MAX_POINTS + int'(req_point_index));
   assign base    = AW'(int'(table_ff) * MAX_POINTS);
   assign pts_raw = table_ff ? head_pts_ff : ankle_pts_ff;

   always_comb begin
      if (pts_raw < POINTS_W'(2)) begin
         last_off = OW'(1);
      end else if (int'(pts_raw) > MAX_POINTS) begin
         last_off = OW'(MAX_POINTS - 1);
      end else begin
         last_off = OW'(int'(pts_raw) - 1);
      end
   end

   always_comb begin
      case (state_ff)
         S_IDLE:    rd_addr = AW'(int'(req_table_select) * MAX_POINTS);
         S_RD_LAST: rd_addr = base + AW'(last_off);
         S_CHK:     rd_addr = base + AW'(1);
         S_SCAN:    rd_addr = base + AW'(idx_ff) + AW'(1);
         default:   rd_addr = base;
      endcase
   end

   jli_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && (req_opcode == OP_LOAD) && load_ok),
      .wr_addr (wr_addr),
      .wr_data ({req_point_high, req_point_low, req_point_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign ent_x = rd_entry[VALUE_W-1:0];
   assign ent_y = col_ff ? rd_entry[3*VALUE_W-1:2*VALUE_W] : rd_entry[2*VALUE_W-1:VALUE_W];
   assign found = (qx_ff > prev_x_ff) && (qx_ff <= ent_x);
   assign dx_full = {ent_x[VALUE_W-1], ent_x} - {prev_x_ff[VALUE_W-1], prev_x_ff};

   assign prod_mag = prod_ff[PROD_W-1] ? DVD_W'(-prod_ff) : DVD_W'(prod_ff);
   assign div_ctrl.start = (state_ff == S_DIV);

   jli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctrl.start),
      .dividend (prod_mag),
      .divisor  (dx_ff),
      .done     (div_ctrl.done),
      .quotient (quot)
   );

   assign quot_s = prod_ff[PROD_W-1] ? -$signed({2'b00, quot[VALUE_W:0]})
                                     : $signed({2'b00, quot[VALUE_W:0]});
   assign sum = $signed({{3{prev_y_ff[VALUE_W-1]}}, prev_y_ff}) + quot_s;
   assign neg = -$signed({{3{pre_ff[VALUE_W-1]}}, pre_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == OP_QUERY)) begin
               state_in = (int'(req_table_select) < NUM_TABLES) ? S_RD_LAST : S_EMIT;
            end
         end
         S_RD_LAST: state_in = S_CHK;
         S_CHK: begin
            if ((qx_ff <= prev_x_ff) || (qx_ff >= ent_x)) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (found) begin
               state_in = S_MUL;
            end else if (idx_ff == last_off) begin
               state_in = S_EMIT;
            end
         end
         S_MUL:  state_in = S_DIV;
         S_DIV:  state_in = S_WAIT;
         S_WAIT: begin
            if (div_ctrl.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      table_in     = table_ff;
      col_in       = col_ff;
      mirror_in    = mirror_ff;
      qx_in        = qx_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      last_y_in    = last_y_ff;
      idx_in       = idx_ff;
      dy_in        = dy_ff;
      dx_in        = dx_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      pre_in       = pre_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      case (state_ff)
         S_IDLE: begin
            table_in  = req_table_select;
            col_in    = req_query_bound ^ req_query_mirror;
            mirror_in = req_query_mirror;
            qx_in     = req_query_x;
            pre_in    = '0;
         end
         S_RD_LAST: begin
            prev_x_in = ent_x;
            prev_y_in = ent_y;
         end
         S_CHK: begin
            last_y_in = ent_y;
            idx_in    = OW'(1);
            if (qx_ff <= prev_x_ff) begin
               pre_in = prev_y_ff;
            end else if (qx_ff >= ent_x) begin
               pre_in = ent_y;
            end
         end
         S_SCAN: begin
            if (found) begin
               dx_in = dx_full[VALUE_W-1:0];
               dy_in = {ent_y[VALUE_W-1], ent_y} - {prev_y_ff[VALUE_W-1], prev_y_ff};
               t_in  = VALUE_W'({qx_ff[VALUE_W-1], qx_ff} - {prev_x_ff[VALUE_W-1], prev_x_ff});
            end else if (idx_ff == last_off) begin
               pre_in = last_y_ff;
            end else begin
               prev_x_in = ent_x;
               prev_y_in = ent_y;
               idx_in    = idx_ff + 1'b1;
            end
         end
         S_MUL: begin
            prod_in = PROD_W'(dy_ff * $signed({1'b0, t_ff}));
         end
         S_WAIT: begin
            if (div_ctrl.done) begin
               pre_in = sat_value(sum);
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = mirror_ff ? sat_value(neg) : pre_ff;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      ankle_pts_in = ankle_pts_ff;
      head_pts_in  = head_pts_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ANKLE_POINTS: ankle_pts_in = csr_data;
            CSR_HEAD_POINTS:  head_pts_in  = csr_data;
            default:          ankle_pts_in = ankle_pts_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ankle_pts_ff <= POINTS_W'(16);
         head_pts_ff  <= POINTS_W'(16);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ankle_pts_ff <= ankle_pts_in;
         head_pts_ff  <= head_pts_in;
      end
      table_ff     <= table_in;
      col_ff       <= col_in;
      mirror_ff    <= mirror_in;
      qx_ff        <= qx_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      last_y_ff    <= last_y_in;
      idx_ff       <= idx_in;
      dy_ff        <= dy_in;
      dx_ff        <= dx_in;
      t_ff         <= t_in;
      prod_ff      <= prod_in;
      pre_ff       <= pre_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_limit_value = rsp_value_ff;
endmodule

@@ hw/rtl/jli_checker.sv @@
// port-level checker for the joint limit interpolator and its bind
`include "joint_limit_interpolator_defines.svh"

module jli_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_opcode,
   input logic rsp_valid
);
   import jli_pkg::*;

   `JLI_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `JLI_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy)
   `JLI_ASSERT_NEXT(a_query_busy, clock, reset, start && !busy && (req_opcode == OP_QUERY), busy)
   `JLI_ASSERT_NEXT(a_load_quiet, clock, reset, start && !busy && (req_opcode == OP_LOAD), !busy && !rsp_valid)
   `JLI_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !busy && !rsp_valid)
endmodule

bind joint_limit_interpolator jli_checker u_jli_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid)
);

@@ sim/tb_joint_limit_interpolator.sv @@
// self-checking testbench for the joint limit interpolator: breakpoint loads and limit queries
`timescale 1ns / 1ps

class limit_board;
   int          bp_x[2][16];
   int          bp_y[2][16][2];
   int unsigned points_used[2];
   shortint     expected_limits[$];
   int          mismatches;

   function new();
      points_used[0] = 16;
      points_used[1] = 16;
   endfunction

   function void set_points(int tbl, int unsigned n);
      points_used[tbl] = n;
   endfunction

   function int lookup(int tbl, int col, int x);
      int unsigned n;
      longint      dx;
      longint      dy;
      longint      t;
      longint      v;
      n = points_used[tbl];
      if (n < 2) n = 2;
      if (n > 16) n = 16;
      if (x <= bp_x[tbl][0]) return bp_y[tbl][0][col];
      if (x >= bp_x[tbl][n-1]) return bp_y[tbl][n-1][col];
      for (int i = 0; i < n - 1; i++) begin
         if (x > bp_x[tbl][i] && x <= bp_x[tbl][i+1]) begin
            dx = longint'(bp_x[tbl][i+1]) - bp_x[tbl][i];
            dy = longint'(bp_y[tbl][i+1][col]) - bp_y[tbl][i][col];
            t  = longint'(x) - bp_x[tbl][i];
            if (dx <= 0) return bp_y[tbl][i][col];
            v = bp_y[tbl][i][col] + (dy * t) / dx;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return int'(v);
         end
      end
      return bp_y[tbl][n-1][col];
   endfunction

   function void note(bit op, bit tbl, bit [3:0] idx, shortint px, shortint plo,
                      shortint phi, shortint qx, bit bound, bit mirror);
      int v;
      if (op == jli_pkg::OP_LOAD) begin
         bp_x[tbl][idx]    = px;
         bp_y[tbl][idx][0] = plo;
         bp_y[tbl][idx][1] = phi;
      end else begin
         v = lookup(tbl, bound ^ mirror, qx);
         if (mirror) begin
            v = -v;
            if (v > 32767) v = 32767;
         end
         expected_limits.push_back(shortint'(v));
      end
   endfunction

   function void check(shortint actual);
      shortint want;
      if (expected_limits.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result limit_value=%0d", actual);
         return;
      end
      want = expected_limits.pop_front();
      if (want !== actual) begin
         mismatches++;
         if (mismatches <= 10)
            $display("limit_value mismatch: expected %0d actual %0d", want, actual);
      end
   endfunction

   function int pending();
      return expected_limits.size();
   endfunction
endclass

module tb_joint_limit_interpolator;
   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_opcode = 1'b0;
   logic        req_table_select = 1'b0;
   logic [3:0]  req_point_index = '0;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_low = '0;
   logic signed [15:0] req_point_high = '0;
   logic signed [15:0] req_query_x = '0;
   logic        req_query_bound = 1'b0;
   logic        req_query_mirror = 1'b0;
   logic        rsp_valid;
   logic signed [15:0] rsp_limit_value;
   logic        csr_write_enable = 1'b0;
   logic [jli_pkg::CSR_INDEX_W-1:0] csr_index = jli_pkg::CSR_ANKLE_POINTS;
   logic [jli_pkg::POINTS_W-1:0]    csr_data = '0;

   limit_board board = new();
   int         cycles = 0;
   bit         idling_on = 1'b1;

   joint_limit_interpolator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_table_select(req_table_select),
      .req_point_index(req_point_index), .req_point_x(req_point_x),
      .req_point_low(req_point_low), .req_point_high(req_point_high),
      .req_query_x(req_query_x), .req_query_bound(req_query_bound),
      .req_query_mirror(req_query_mirror), .rsp_valid(rsp_valid),
      .rsp_limit_value(rsp_limit_value), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("joint_limit_interpolator verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy)
         board.note(req_opcode, req_table_select, req_point_index, req_point_x,
                    req_point_low, req_point_high, req_query_x, req_query_bound,
                    req_query_mirror);
      if (!reset && rsp_valid) board.check(rsp_limit_value);
   end

   task automatic send(bit op, bit tbl, bit [3:0] idx, shortint px, shortint plo,
                       shortint phi, shortint qx, bit bound, bit mirror);
      req_opcode <= op;
      req_table_select <= tbl;
      req_point_index <= idx;
      req_point_x <= px;
      req_point_low <= plo;
      req_point_high <= phi;
      req_query_x <= qx;
      req_query_bound <= bound;
      req_query_mirror <= mirror;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic load(bit tbl, bit [3:0] idx, shortint px, shortint plo, shortint phi);
      send(jli_pkg::OP_LOAD, tbl, idx, px, plo, phi, shortint'($urandom), $urandom,
           $urandom);
   endtask

   task automatic query(bit tbl, shortint qx, bit bound, bit mirror);
      send(jli_pkg::OP_QUERY, tbl, $urandom, shortint'($urandom), shortint'($urandom),
           shortint'($urandom), qx, bound, mirror);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0 || busy) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_points(bit [4:0] ankle_n, bit [4:0] head_n);
      csr_write_enable <= 1'b1;
      csr_index <= jli_pkg::CSR_ANKLE_POINTS;
      csr_data <= ankle_n;
      @(posedge clock);
      csr_index <= jli_pkg::CSR_HEAD_POINTS;
      csr_data <= head_n;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_points(0, ankle_n);
      board.set_points(1, head_n);
   endtask

   // strictly increasing abscissae with random ordinates
   task automatic reload_table(bit tbl);
      int x;
      int stride;
      stride = ($urandom_range(0, 3) == 0) ? 40 : 3000;
      x = $urandom_range(0, 12000) - 32768;
      for (int i = 0; i < 16; i++) begin
         load(tbl, i, shortint'(x), shortint'($urandom), shortint'($urandom));
         x += $urandom_range(1, stride);
      end
   endtask

   task automatic random_request();
      int  pick;
      bit  tbl;
      int  qx;
      tbl = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         reload_table(tbl);
      end else if (pick < 12) begin
         load(tbl, $urandom, shortint'($urandom), shortint'($urandom), shortint'($urandom));
      end else begin
         if ($urandom_range(0, 2) == 0) qx = $signed(16'($urandom));
         else qx = board.bp_x[tbl][$urandom_range(0, 15)] + $urandom_range(0, 600) - 300;
         if (qx > 32767) qx = 32767;
         if (qx < -32768) qx = -32768;
         query(tbl, shortint'(qx), $urandom, $urandom);
      end
   endtask

   initial begin
      bit [4:0] ankle_settings[7] = '{16, 2, 0, 1, 31, 17, 9};
      bit [4:0] head_settings[7]  = '{16, 2, 31, 17, 0, 1, 5};
      int mid;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_points(16, 16);

      for (int i = 0; i < 16; i++) begin
         load(0, i, shortint'(-32768 + i * 4369), (i % 2) ? 16'sh7fff : 16'sh8000,
              shortint'(i * 3000 - 20000));
         load(1, i, shortint'(-8000 + i * 1000), (i == 0) ? 16'sh8000 : shortint'(i * 2000),
              shortint'(32767 - i * 4000));
      end
      for (int t = 0; t < 2; t++)
         for (int b = 0; b < 2; b++)
            for (int m = 0; m < 2; m++) begin
               mid = (board.bp_x[t][3] + board.bp_x[t][4]) / 2 + 1;
               query(t, 16'sh8000, b, m);
               query(t, shortint'(mid), b, m);
               query(t, 16'sh7fff, b, m);
            end
      query(0, shortint'(board.bp_x[0][5]), 1'b0, 1'b1);
      query(1, shortint'(board.bp_x[1][15]), 1'b1, 1'b0);

      // repeated abscissa gives a zero span, a falling one leaves no segment
      load(1, 4, shortint'(board.bp_x[1][3]), 16'sh1234, 16'sh8000);
      query(1, shortint'(board.bp_x[1][3] + 500), 1'b0, 1'b0);
      load(1, 6, 16'sh8000, 16'sh0777, 16'sh7fff);
      query(1, shortint'(board.bp_x[1][7] - 10), 1'b1, 1'b1);
      settle();

      for (int ph = 0; ph < 7; ph++) begin
         set_points(ankle_settings[ph], head_settings[ph]);
         if (ph == 6) idling_on = 1'b0;
         for (int n = 0; n < 95; n++) begin
            random_request();
            if (ph == 2 && n == 70) settle();
         end
         settle();
      end

      if (board.mismatches == 0) $display("joint_limit_interpolator verification clean");
      else $display("joint_limit_interpolator verification failed");
      $finish;
   end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/jli_pkg.sv
hw/rtl/jli_ram.sv
hw/rtl/jli_div.sv
hw/rtl/joint_limit_interpolator.sv
hw/rtl/jli_checker.sv
sim/tb_joint_limit_interpolator.sv
